[rtl/mcpwm_pkg.sv]
// shared constants, codes and word types for the multi-channel soft pwm block
package mcpwm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int BASE_RATE_US_DEF = 50;

    localparam int PIN_W       = 5;
    localparam int TIME_W      = 24;
    localparam int MASK_W      = 17;
    localparam int COUNT_W     = 32;
    localparam int PIN_SPECIAL = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    // what a word travelling down the cell row asks of each cell
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MATCH = 2'd1,
        OP_ALLOC = 2'd2
    } op_t;

    // word handed from cell to cell
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [PIN_W-1:0]   pin;
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  duty;
        logic               hit;
        logic               acc;
        logic               wr;
        logic               lvl;
        logic [MASK_W-1:0]  set_mask;
        logic [MASK_W-1:0]  clr_mask;
    } tok_t;

    // one result word
    typedef struct packed {
        logic               acc;
        logic               wr;
        logic               lvl;
        logic [MASK_W-1:0]  set_mask;
        logic [MASK_W-1:0]  clr_mask;
    } res_t;

endpackage

[rtl/mcpwm_div.sv]
// divider of two operands by the constant base rate, by reciprocal multiply
module mcpwm_div #(
    parameter int BASE_RATE_US = mcpwm_pkg::BASE_RATE_US_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mcpwm_pkg::TIME_W-1:0]  num_a,
    input  logic [mcpwm_pkg::TIME_W-1:0]  num_b,
    output logic                          done,
    output logic [mcpwm_pkg::TIME_W-1:0]  quo_a,
    output logic [mcpwm_pkg::TIME_W-1:0]  quo_b
);

    localparam int TW  = mcpwm_pkg::TIME_W;
    // shift that makes the rounded-up reciprocal exact for every TW-bit operand
    localparam int RS  = TW + $clog2(BASE_RATE_US);
    localparam int PRW = RS + TW + 1;
    localparam logic [TW:0] RECIP =
        (TW+1)'(((64'd1 << RS) + 64'(BASE_RATE_US) - 64'd1) / 64'(BASE_RATE_US));

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [TW-1:0]  xa_reg, xa_next, xb_reg, xb_next;
    logic [TW-1:0]  qa_reg, qa_next, qb_reg, qb_next;
    logic [PRW-1:0] prod_a, prod_b;

    // operand times reciprocal; the quotient sits above the shift
    assign prod_a = PRW'(xa_reg) * PRW'(RECIP);
    assign prod_b = PRW'(xb_reg) * PRW'(RECIP);

    always_comb begin
        busy_next = start;
        done_next = busy_reg;
        xa_next   = xa_reg;
        xb_next   = xb_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        if (start) begin
            xa_next = num_a;
            xb_next = num_b;
        end
        if (busy_reg) begin
            qa_next = prod_a[RS +: TW];
            qb_next = prod_b[RS +: TW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        xa_reg <= xa_next;
        xb_reg <= xb_next;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
    end

    assign done  = done_reg;
    assign quo_a = qa_reg;
    assign quo_b = qb_reg;

endmodule

[rtl/mcpwm_cell.sv]
// one pwm channel slot; acts on the word passing through and hands it on
module mcpwm_cell #(
    parameter int QW = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mcpwm_pkg::tok_t  tok_in,
    output mcpwm_pkg::tok_t  tok_out
);

    localparam int TW = mcpwm_pkg::TIME_W;
    localparam int NW = mcpwm_pkg::COUNT_W;
    localparam int MW = mcpwm_pkg::MASK_W;
    localparam int PW = mcpwm_pkg::PIN_W;

    logic          used_reg, used_next;
    logic [PW-1:0] pin_reg, pin_next;
    logic          level_reg, level_next;
    logic [NW-1:0] count_reg, count_next;
    logic [QW-1:0] period_reg, period_next;
    logic [QW-1:0] duty_reg, duty_next;
    mcpwm_pkg::tok_t tok_reg, tok_next;

    logic [NW-1:0] cnt_dec;
    logic [TW-1:0] per_ext, duty_ext;
    logic [MW-1:0] pin_bit;

    assign cnt_dec  = count_reg - NW'(1);
    assign per_ext  = TW'(period_reg);
    assign duty_ext = TW'(duty_reg);
    assign pin_bit  = MW'(1) << pin_reg;

    always_comb begin
        used_next   = used_reg;
        pin_next    = pin_reg;
        level_next  = level_reg;
        count_next  = count_reg;
        period_next = period_reg;
        duty_next   = duty_reg;
        tok_next    = tok_in;
        if (tok_in.valid) begin
            case (tok_in.op)
                mcpwm_pkg::OP_TICK: begin
                    if (used_reg) begin
                        count_next = cnt_dec;
                        if (cnt_dec == '0 && duty_reg != '0 && duty_reg != period_reg) begin
                            if (level_reg) begin
                                tok_next.clr_mask = tok_in.clr_mask | pin_bit;
                                count_next = NW'(period_reg - duty_reg);
                            end else begin
                                tok_next.set_mask = tok_in.set_mask | pin_bit;
                                count_next = NW'(duty_reg);
                            end
                            level_next = ~level_reg;
                        end
                    end
                end
                mcpwm_pkg::OP_MATCH: begin
                    if (used_reg && pin_reg == tok_in.pin) begin
                        tok_next.hit = 1'b1;
                        tok_next.acc = 1'b1;
                        if (tok_in.period == '0) begin
                            // removal frees the slot and drives the pin low
                            used_next    = 1'b0;
                            tok_next.wr  = 1'b1;
                            tok_next.lvl = 1'b0;
                        end else if (!(per_ext == tok_in.period && duty_ext == tok_in.duty)) begin
                            period_next = tok_in.period[QW-1:0];
                            duty_next   = tok_in.duty[QW-1:0];
                            if (count_reg == '0 || count_reg > NW'(tok_in.period)) begin
                                level_next   = 1'b1;
                                count_next   = NW'(tok_in.duty);
                                tok_next.wr  = 1'b1;
                                tok_next.lvl = 1'b1;
                            end
                            if (tok_in.duty == '0 || tok_in.duty == tok_in.period) begin
                                tok_next.wr  = 1'b1;
                                tok_next.lvl = (tok_in.duty == tok_in.period);
                            end
                        end
                    end
                end
                mcpwm_pkg::OP_ALLOC: begin
                    // first free slot claims the new channel, which always starts high
                    // unless its duty is zero
                    if (!used_reg && !tok_in.hit) begin
                        used_next    = 1'b1;
                        pin_next     = tok_in.pin;
                        period_next  = tok_in.period[QW-1:0];
                        duty_next    = tok_in.duty[QW-1:0];
                        level_next   = 1'b1;
                        count_next   = NW'(tok_in.duty);
                        tok_next.hit = 1'b1;
                        tok_next.acc = 1'b1;
                        tok_next.wr  = 1'b1;
                        tok_next.lvl = (tok_in.duty != '0);
                    end
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        pin_reg    <= pin_next;
        level_reg  <= level_next;
        count_reg  <= count_next;
        period_reg <= period_next;
        duty_reg   <= duty_next;
    end

    assign tok_out = tok_reg;

endmodule

[rtl/multi_channel_soft_pwm.sv]
// top level: command sequencer, base-rate divider and the row of channel cells
//
//  channel   | ports                            | word contents
//  ----------+----------------------------------+------------------------------------------
//  input     | s_tvalid s_tready s_tdata s_tuser| tuser: command (0 tick, 1 set)
//            |                                  | tdata: pin, period_us, duty_us
//  result    | m_tvalid m_tready m_tdata        | tdata: accepted, pin_write, pin_level,
//            |                                  |        set_mask, clear_mask
//  config    | cfg_wr_en cfg_wr_data            | valid_pins, written when cfg_wr_en is high
//
// a tick word walks the cell row one cell per cycle
// a set word first passes through the reciprocal divider, then walks the row, and a
// second walk claims a free slot for a new pin; a rejected set skips divider and row
// one word is worked on at a time; the next is taken while a result still waits
// in the output register; a stalled m_tready holds that result, and a next result
// waits in ST_DONE with s_tready low until the output register is free
// reset empties every slot and sets valid_pins to all ones
module multi_channel_soft_pwm #(
    parameter int MAX_CHANNELS = mcpwm_pkg::MAX_CHANNELS_DEF,
    parameter int BASE_RATE_US = mcpwm_pkg::BASE_RATE_US_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mcpwm_pkg::IN_TDATA_W-1:0]   s_tdata,   // pin[4:0] period_us[28:5] duty_us[52:29]
    input  logic                               s_tuser,   // command
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mcpwm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // accepted[0] pin_write[1]
                                                          // pin_level[2] set_mask[19:3]
                                                          // clear_mask[36:20]
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [mcpwm_pkg::MASK_W-1:0]       cfg_wr_data // valid_pins, bit 16 ignored
);

    localparam int TW = mcpwm_pkg::TIME_W;
    localparam int PW = mcpwm_pkg::PIN_W;
    localparam int NP = mcpwm_pkg::PIN_SPECIAL;
    // width of a period or duty once scaled to base-rate units
    localparam int QW = $clog2(((2 ** TW) - 1) / BASE_RATE_US + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_RUN1 = 5'b00100,
        ST_RUN2 = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [NP-1:0] valid_pins_reg;
    logic [PW-1:0] pin_reg, pin_next;
    mcpwm_pkg::tok_t inj_reg, inj_next;
    mcpwm_pkg::res_t res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    mcpwm_pkg::res_t m_data_reg, m_data_next;

    // unpacked input fields
    logic [PW-1:0] in_pin;
    logic [TW-1:0] in_period, in_duty;
    logic          pin_ok, time_ok;

    logic          div_start, div_done;
    logic [TW-1:0] div_qa, div_qb;

    mcpwm_pkg::tok_t chain [MAX_CHANNELS+1];
    mcpwm_pkg::tok_t chain_out;

    assign in_pin    = s_tdata[PW-1:0];
    assign in_period = s_tdata[PW+TW-1:PW];
    assign in_duty   = s_tdata[PW+2*TW-1:PW+TW];

    // pin 16 is always allowed, pins 0..15 through valid_pins
    assign pin_ok  = (in_pin == PW'(NP)) ||
                     (!in_pin[PW-1] && valid_pins_reg[in_pin[PW-2:0]]);
    // zero period removes; otherwise at least two base units and duty within period
    assign time_ok = (in_period == '0) ||
                     (in_period >= TW'(2 * BASE_RATE_US) && in_duty <= in_period);

    assign s_tready = (state_reg == ST_IDLE);

    mcpwm_div #(
        .BASE_RATE_US (BASE_RATE_US)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_a   (in_period),
        .num_b   (in_duty),
        .done    (div_done),
        .quo_a   (div_qa),
        .quo_b   (div_qb)
    );

    // row of channel cells, one slot each; a word moves one cell per cycle
    assign chain[0] = inj_reg;

    for (genvar gi = 0; gi < MAX_CHANNELS; gi++) begin : g_cell
        mcpwm_cell #(
            .QW (QW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[gi]),
            .tok_out (chain[gi+1])
        );
    end

    assign chain_out = chain[MAX_CHANNELS];

    // command sequencer
    always_comb begin
        state_next     = state_reg;
        pin_next       = pin_reg;
        inj_next       = '0;
        res_next       = res_reg;
        div_start      = 1'b0;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        // tick: always accepted, masks gather along the row
                        inj_next.valid = 1'b1;
                        inj_next.op    = mcpwm_pkg::OP_TICK;
                        inj_next.acc   = 1'b1;
                        state_next     = ST_RUN1;
                    end else if (pin_ok && time_ok) begin
                        div_start  = 1'b1;
                        pin_next   = in_pin;
                        state_next = ST_DIV;
                    end else begin
                        // bad pin or bad timing: rejected, nothing driven
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    inj_next.valid  = 1'b1;
                    inj_next.op     = mcpwm_pkg::OP_MATCH;
                    inj_next.pin    = pin_reg;
                    inj_next.period = div_qa;
                    inj_next.duty   = div_qb;
                    state_next      = ST_RUN1;
                end
            end
            ST_RUN1: begin
                if (chain_out.valid) begin
                    if (chain_out.op == mcpwm_pkg::OP_MATCH && !chain_out.hit &&
                        chain_out.period != '0) begin
                        // unknown pin: second walk hands it to the first free slot
                        inj_next       = chain_out;
                        inj_next.op    = mcpwm_pkg::OP_ALLOC;
                        state_next     = ST_RUN2;
                    end else begin
                        // tick, update, removal, or removal of an absent pin
                        res_next.acc      = chain_out.acc;
                        res_next.wr       = chain_out.wr;
                        res_next.lvl      = chain_out.lvl;
                        res_next.set_mask = chain_out.set_mask;
                        res_next.clr_mask = chain_out.clr_mask;
                        state_next        = ST_DONE;
                    end
                end
            end
            ST_RUN2: begin
                if (chain_out.valid) begin
                    // no slot claimed leaves acc low: table full
                    res_next.acc      = chain_out.acc;
                    res_next.wr       = chain_out.wr;
                    res_next.lvl      = chain_out.lvl;
                    res_next.set_mask = chain_out.set_mask;
                    res_next.clr_mask = chain_out.clr_mask;
                    state_next        = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand the result over as soon as the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_pins_reg <= '1;
            inj_reg.valid  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inj_reg     <= inj_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                valid_pins_reg <= cfg_wr_data[NP-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pin_reg    <= pin_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg.clr_mask, m_data_reg.set_mask,
                       m_data_reg.lvl, m_data_reg.wr, m_data_reg.acc};

endmodule
